// ===== src/dcb_pkg.sv =====
// ----------------------------------------------------------------------------
// dcb_pkg: shared types and constants of the descriptor chain builder
// Holds the request, queue entry, configuration and result types plus the
// fixed field widths and codes used by front, queue and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcb_pkg;

   // fixed field widths
   localparam int ADDR_W   = 64;
   localparam int BYTES_W  = 18;
   localparam int SIZE_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int SLOT_W   = 8;
   localparam int PGIDX_W  = 3;
   localparam int CSR_IDX_W = 3;

   // descriptor geometry
   localparam int DESC_BYTES = 20;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MAP    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BASE_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BASE_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BASE_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BASE_3 = 3'd4;

   // reset values of the registers
   localparam logic [PGIDX_W-1:0] PAGE_COUNT_RESET = 3'd4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // classified operation carried through the queue
   typedef enum logic [1:0] {
      OP_START,
      OP_MAP,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [BYTES_W-1:0]  bytes;
   } entry_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [PGIDX_W-1:0]         page_count;
      logic [3:0][ADDR_W-1:0]     page_base;
   } cfg_type;

   // one emitted descriptor
   typedef struct packed {
      logic [ADDR_W-1:0]  slot_addr;
      logic [ADDR_W-1:0]  page_word;
      logic [SIZE_W-1:0]  size_word;
      logic [ADDR_W-1:0]  next_word;
      logic               last;
      logic               overflow;
   } res_type;

   // back end sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_MAP
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/dcb_front.sv =====
// ----------------------------------------------------------------------------
// dcb_front: request intake and classification
// Takes request beats, drops those that cannot change anything (unused code,
// map shorter than one page) and pushes the rest into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcb_front #(
   parameter int DESCS_PER_PAGE = 204
) (
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [dcb_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [dcb_pkg::ADDR_W-1:0]    req_block_addr,
   input  wire logic [dcb_pkg::BYTES_W-1:0]   req_block_bytes,
   input  wire logic                          q_full,
   output logic                               q_push,
   output dcb_pkg::entry_type                 q_data
);
   import dcb_pkg::*;

   localparam int PAGE_BYTES = DESCS_PER_PAGE * DESC_BYTES;
   localparam logic [BYTES_W-1:0] PAGE_BYTES_W = BYTES_W'(PAGE_BYTES);

   logic keep;

   // stall only on a full queue
   assign req_stall = q_full;

   // classify the beat
   always_comb begin
      keep       = 1'b0;
      q_data.op    = OP_START;
      q_data.addr  = req_block_addr;
      q_data.bytes = req_block_bytes;
      case (req_func)
         FUNC_START: begin
            keep      = 1'b1;
            q_data.op = OP_START;
         end
         FUNC_MAP: begin
            // less than one whole page maps nothing
            keep      = (req_block_bytes >= PAGE_BYTES_W);
            q_data.op = OP_MAP;
         end
         FUNC_FINISH: begin
            keep      = 1'b1;
            q_data.op = OP_FINISH;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = req_valid && !q_full && keep;

endmodule

`default_nettype wire

// ===== src/dcb_queue.sv =====
// ----------------------------------------------------------------------------
// dcb_queue: short queue between front and back
// Small first-in first-out buffer of classified requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcb_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire dcb_pkg::entry_type   push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      valid,
   output dcb_pkg::entry_type        pop_data
);
   import dcb_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full     = (count_ff == DEPTH_C);
   assign valid    = (count_ff != '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/dcb_back.sv =====
// ----------------------------------------------------------------------------
// dcb_back: descriptor sequencer
// Pops classified requests, walks the pages of a block one per cycle when not
// stalled, allocates descriptor slots and drives the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcb_back #(
   parameter int DESCS_PER_PAGE      = 204,
   parameter int MAX_DESC_PAGES      = 4,
   parameter int MAX_PAGES_PER_BLOCK = 47
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dcb_pkg::cfg_type     cfg,
   input  wire logic                 q_valid,
   input  wire dcb_pkg::entry_type   q_data,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output dcb_pkg::res_type          rsp
);
   import dcb_pkg::*;

   localparam int PAGE_BYTES = DESCS_PER_PAGE * DESC_BYTES;
   localparam int CNT_W      = $clog2(MAX_PAGES_PER_BLOCK + 1);
   localparam logic [BYTES_W-1:0] PAGE_BYTES_B = BYTES_W'(PAGE_BYTES);
   localparam logic [ADDR_W-1:0]  PAGE_BYTES_A = ADDR_W'(PAGE_BYTES);
   localparam logic [ADDR_W-1:0]  DESC_BYTES_A = ADDR_W'(DESC_BYTES);
   localparam logic [SIZE_W-1:0]  SIZE_WORD    = SIZE_W'(PAGE_BYTES) | SIZE_W'(7);
   localparam logic [SLOT_W-1:0]  SLOTS_FULL   = SLOT_W'(DESCS_PER_PAGE);
   localparam logic [PGIDX_W-1:0] MAX_PAGES_C  = PGIDX_W'(MAX_DESC_PAGES);
   localparam logic [CNT_W-1:0]   MAX_CNT      = CNT_W'(MAX_PAGES_PER_BLOCK);
   localparam logic [ADDR_W-1:0]  LINK_FLAG    = 64'h2;
   localparam logic [ADDR_W-1:0]  PAGE_FLAGS   = 64'h7;

   back_state_type        state_ff, state_in;
   logic                  halted_ff, halted_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [ADDR_W-1:0]     pend_page_ff, pend_page_in;
   logic [ADDR_W-1:0]     cursor_ff, cursor_in;
   logic [SLOT_W-1:0]     slots_ff, slots_in;
   logic [PGIDX_W-1:0]    npi_ff, npi_in;
   logic [BYTES_W-1:0]    rem_ff, rem_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  out_valid_ff, out_valid_in;
   res_type               out_ff, out_in;

   logic                  out_free;
   logic [PGIDX_W-1:0]    usable;
   logic                  more;
   logic [BYTES_W-1:0]    rem_after;
   logic [CNT_W-1:0]      cnt_inc;
   logic                  more_after;
   logic                  wrap;
   logic [ADDR_W-1:0]     cur;
   logic [SLOT_W-1:0]     slots_eff;
   logic                  emit;
   logic [ADDR_W-1:0]     emit_next;
   logic                  emit_last;
   logic                  emit_ovf;

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // output register can take a new beat
   assign out_free = !out_valid_ff || !rsp_stall;

   // usable descriptor pages, clamped to the legal range
   always_comb begin
      if (cfg.page_count == '0) begin
         usable = PGIDX_W'(1);
      end else if (cfg.page_count > MAX_PAGES_C) begin
         usable = MAX_PAGES_C;
      end else begin
         usable = cfg.page_count;
      end
   end

   // page walk conditions
   assign more       = (rem_ff >= PAGE_BYTES_B) && (cnt_ff < MAX_CNT);
   assign rem_after  = rem_ff - PAGE_BYTES_B;
   assign cnt_inc    = cnt_ff + 1'b1;
   assign more_after = (rem_after >= PAGE_BYTES_B) && (cnt_inc < MAX_CNT);
   assign wrap       = (slots_ff == '0);
   assign cur        = wrap ? cfg.page_base[npi_ff[1:0]] : cursor_ff;
   assign slots_eff  = wrap ? SLOTS_FULL : slots_ff;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      halted_in     = halted_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_page_in  = pend_page_ff;
      cursor_in     = cursor_ff;
      slots_in      = slots_ff;
      npi_in        = npi_ff;
      rem_in        = rem_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      q_pop         = 1'b0;
      emit          = 1'b0;
      emit_next     = LINK_FLAG;
      emit_last     = 1'b0;
      emit_ovf      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_data.op)
                  OP_START: begin
                     halted_in     = 1'b0;
                     pend_valid_in = 1'b0;
                     pend_slot_in  = '0;
                     pend_page_in  = '0;
                     cursor_in     = cfg.page_base[0];
                     slots_in      = SLOTS_FULL;
                     npi_in        = PGIDX_W'(1);
                  end
                  OP_FINISH: begin
                     if (!halted_ff) begin
                        // close the loop back to the first descriptor page
                        emit          = pend_valid_ff;
                        emit_next     = cfg.page_base[0] | LINK_FLAG;
                        emit_last     = 1'b1;
                        pend_valid_in = 1'b0;
                        halted_in     = 1'b1;
                     end
                  end
                  OP_MAP: begin
                     if (!halted_ff) begin
                        rem_in   = q_data.bytes;
                        addr_in  = q_data.addr;
                        cnt_in   = '0;
                        state_in = ST_MAP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAP: begin
            if (out_free) begin
               if (!more) begin
                  state_in = ST_IDLE;
               end else if (wrap && (npi_ff >= usable)) begin
                  // descriptor pages exhausted: flush unlinked and halt
                  emit          = pend_valid_ff;
                  emit_next     = LINK_FLAG;
                  emit_last     = 1'b1;
                  emit_ovf      = 1'b1;
                  pend_valid_in = 1'b0;
                  halted_in     = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  // link the held descriptor to this slot, hold the new one
                  emit          = pend_valid_ff;
                  emit_next     = cur | LINK_FLAG;
                  emit_last     = !more_after;
                  if (wrap) begin
                     npi_in = npi_ff + 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = cur;
                  pend_page_in  = addr_ff;
                  cursor_in     = cur + DESC_BYTES_A;
                  slots_in      = slots_eff - 1'b1;
                  addr_in       = addr_ff + PAGE_BYTES_A;
                  rem_in        = rem_after;
                  cnt_in        = cnt_inc;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in      = 1'b1;
         out_in.slot_addr  = pend_slot_ff;
         out_in.page_word  = pend_page_ff | PAGE_FLAGS;
         out_in.size_word  = SIZE_WORD;
         out_in.next_word  = emit_next;
         out_in.last       = emit_last;
         out_in.overflow   = emit_ovf;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         halted_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         cursor_ff     <= '0;
         slots_ff      <= SLOTS_FULL;
         npi_ff        <= PGIDX_W'(1);
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         halted_ff     <= halted_in;
         pend_valid_ff <= pend_valid_in;
         cursor_ff     <= cursor_in;
         slots_ff      <= slots_in;
         npi_ff        <= npi_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      pend_page_ff <= pend_page_in;
      rem_ff       <= rem_in;
      addr_ff      <= addr_in;
      cnt_ff       <= cnt_in;
      out_ff       <= out_in;
   end

`ifndef SYNTHESIS
   // a page walk never runs while halted
   a_map_not_halted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAP) |-> !halted_ff)
      else $error("page walk active while halted");

   // an overflow beat always ends its request
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.overflow) |-> out_ff.last)
      else $error("overflow beat without last");

   // next page index stays within the descriptor pages
   a_npi_range: assert property (@(posedge clock) disable iff (reset)
      (npi_ff != '0) && (npi_ff <= MAX_PAGES_C))
      else $error("next page index out of range");

   // requests are only taken between page walks
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE) && q_valid)
      else $error("queue popped outside idle");

   // the free slot count never exceeds one page
   a_slots_range: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= SLOTS_FULL)
      else $error("slot count above page size");
`endif

endmodule

`default_nettype wire

// ===== src/dma_descriptor_chain_builder.sv =====
// ----------------------------------------------------------------------------
// dma_descriptor_chain_builder: circular scatter-gather descriptor chain
// Cuts buffer blocks into pages and emits one linked descriptor per page,
// placed into the configured descriptor pages.
// ----------------------------------------------------------------------------
// A start beat resets the chain, a map beat adds one descriptor per whole page
// of DESCS_PER_PAGE*20 bytes (at most MAX_PAGES_PER_BLOCK), and a finish beat
// links the last descriptor back to the first descriptor page. Each
// descriptor is held until the address of its successor is known, so a map
// beat's results lag one descriptor behind. A map beat walks its pages
// through the back-end sequencer and the result register one page per cycle
// while results do not stall, ending early when the descriptor pages run
// out; unused codes and maps shorter than one page are dropped at intake.
// The front end accepts one beat per cycle while its two-entry queue has
// room. Registers are to be written only while the block is idle; nothing
// in the block enforces this.
`timescale 1ns / 1ps
`default_nettype none

module dma_descriptor_chain_builder #(
   parameter int DESCS_PER_PAGE      = 204,
   parameter int MAX_DESC_PAGES      = 4,
   parameter int MAX_PAGES_PER_BLOCK = 47
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [dcb_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [dcb_pkg::ADDR_W-1:0]       req_block_addr,
   input  wire logic [dcb_pkg::BYTES_W-1:0]      req_block_bytes,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [dcb_pkg::ADDR_W-1:0]            rsp_slot_addr,
   output logic [dcb_pkg::ADDR_W-1:0]            rsp_page_word,
   output logic [dcb_pkg::SIZE_W-1:0]            rsp_size_word,
   output logic [dcb_pkg::ADDR_W-1:0]            rsp_next_word,
   output logic                                  rsp_last,
   output logic                                  rsp_overflow,
   // register write port
   input  wire logic                             csr_we,
   input  wire logic [dcb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dcb_pkg::ADDR_W-1:0]       csr_wdata
);
   import dcb_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        q_push;
   entry_type   q_in;
   logic        q_full;
   logic        q_pop;
   logic        q_valid;
   entry_type   q_out;
   res_type     rsp_data;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PAGE_COUNT:  cfg_in.page_count   = csr_wdata[PGIDX_W-1:0];
            CSR_PAGE_BASE_0: cfg_in.page_base[0] = csr_wdata;
            CSR_PAGE_BASE_1: cfg_in.page_base[1] = csr_wdata;
            CSR_PAGE_BASE_2: cfg_in.page_base[2] = csr_wdata;
            CSR_PAGE_BASE_3: cfg_in.page_base[3] = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_count <= PAGE_COUNT_RESET;
         cfg_ff.page_base  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // intake and classification
   dcb_front #(
      .DESCS_PER_PAGE (DESCS_PER_PAGE)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_block_addr  (req_block_addr),
      .req_block_bytes (req_block_bytes),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_in)
   );

   // decoupling queue
   dcb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out)
   );

   // descriptor sequencer
   dcb_back #(
      .DESCS_PER_PAGE      (DESCS_PER_PAGE),
      .MAX_DESC_PAGES      (MAX_DESC_PAGES),
      .MAX_PAGES_PER_BLOCK (MAX_PAGES_PER_BLOCK)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp_data)
   );

   // result fields
   assign rsp_slot_addr = rsp_data.slot_addr;
   assign rsp_page_word = rsp_data.page_word;
   assign rsp_size_word = rsp_data.size_word;
   assign rsp_next_word = rsp_data.next_word;
   assign rsp_last      = rsp_data.last;
   assign rsp_overflow  = rsp_data.overflow;

endmodule

`default_nettype wire

// ===== tb/tb_dma_descriptor_chain_builder.sv =====
// ----------------------------------------------------------------------------
// tb_dma_descriptor_chain_builder: self-checking bench for the chain builder
// Drives start, map and finish beats, predicts every descriptor the block
// should emit from its own copy of the chain state, and compares each result
// beat field by field, in order. Directed tests cover block sizes, reset-state
// mapping, live register changes and descriptor page overflow; random chains
// then run under several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dma_descriptor_chain_builder;
   import dcb_pkg::*;

   localparam int DESCS_PER_PAGE      = 204;
   localparam int MAX_DESC_PAGES      = 4;
   localparam int MAX_PAGES_PER_BLOCK = 47;
   localparam int PAGE_BYTES          = DESCS_PER_PAGE * DESC_BYTES;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [ADDR_W-1:0] LINK_FLAG   = 64'd2;
   localparam logic [ADDR_W-1:0] UNLINKED    = 64'd2;
   localparam logic [ADDR_W-1:0] PAGE_FLAGS  = 64'd7;
   localparam logic [SIZE_W-1:0] SIZE_WORD   = PAGE_BYTES | 7;
   localparam logic [ADDR_W-1:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int SETTLE_CYCLES = 200;
   localparam int MAX_REPORTS   = 10;
   localparam longint TIMEOUT_NS = 64'd8_000_000;

   logic clock;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [ADDR_W-1:0]    req_block_addr = '0;
   logic [BYTES_W-1:0]   req_block_bytes = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ADDR_W-1:0]    rsp_slot_addr;
   logic [ADDR_W-1:0]    rsp_page_word;
   logic [SIZE_W-1:0]    rsp_size_word;
   logic [ADDR_W-1:0]    rsp_next_word;
   logic                 rsp_last;
   logic                 rsp_overflow;

   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_wdata = '0;

   // idling percentages of the current phase
   int send_idle_pct = 0;
   int rsp_hold_pct  = 0;

   // chain model: register copy and builder state
   logic [PGIDX_W-1:0] cfg_page_count;
   logic [ADDR_W-1:0]  cfg_page_base [4];
   bit                 held_valid;
   logic [ADDR_W-1:0]  held_slot;
   logic [ADDR_W-1:0]  held_page;
   logic [ADDR_W-1:0]  slot_cursor;
   int unsigned        slots_left;
   int unsigned        next_page_idx;
   bit                 chain_halted;

   res_type expected_descs[$];
   res_type seen_desc;
   res_type want_desc;
   int      mismatch_count = 0;

   dma_descriptor_chain_builder #(
      .DESCS_PER_PAGE      (DESCS_PER_PAGE),
      .MAX_DESC_PAGES      (MAX_DESC_PAGES),
      .MAX_PAGES_PER_BLOCK (MAX_PAGES_PER_BLOCK)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_block_addr  (req_block_addr),
      .req_block_bytes (req_block_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot_addr   (rsp_slot_addr),
      .rsp_page_word   (rsp_page_word),
      .rsp_size_word   (rsp_size_word),
      .rsp_next_word   (rsp_next_word),
      .rsp_last        (rsp_last),
      .rsp_overflow    (rsp_overflow),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic int unsigned usable_desc_pages();
      int unsigned n;
      n = 32'(cfg_page_count);
      if (n < 1) n = 1;
      if (n > MAX_DESC_PAGES) n = MAX_DESC_PAGES;
      return n;
   endfunction

   task automatic chain_restart();
      held_valid    = 1'b0;
      held_slot     = '0;
      held_page     = '0;
      slot_cursor   = cfg_page_base[0];
      slots_left    = DESCS_PER_PAGE;
      next_page_idx = 1;
      chain_halted  = 1'b0;
   endtask

   function automatic res_type held_desc(input logic [ADDR_W-1:0] link, input logic ovf);
      res_type d;
      d.slot_addr = held_slot;
      d.page_word = held_page | PAGE_FLAGS;
      d.size_word = SIZE_WORD;
      d.next_word = link;
      d.last      = 1'b0;
      d.overflow  = ovf;
      return d;
   endfunction

   // advance the chain by one accepted beat and queue the descriptors it emits
   task automatic chain_step(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                             input logic [BYTES_W-1:0] b);
      res_type           batch[$];
      int unsigned       pages;
      int unsigned       j;
      logic [ADDR_W-1:0] page_ptr;
      page_ptr = a;
      if (f == FUNC_START) begin
         chain_restart();
      end else if (!chain_halted && f == FUNC_FINISH) begin
         // close the loop back to the first descriptor page
         if (held_valid) batch.push_back(held_desc(cfg_page_base[0] | LINK_FLAG, 1'b0));
         held_valid   = 1'b0;
         chain_halted = 1'b1;
      end else if (!chain_halted && f == FUNC_MAP) begin
         pages = b / PAGE_BYTES;
         if (pages > MAX_PAGES_PER_BLOCK) pages = MAX_PAGES_PER_BLOCK;
         j = 0;
         while (j < pages && !chain_halted) begin
            // current descriptor page used up: move on or give up
            if (slots_left == 0) begin
               if (next_page_idx >= usable_desc_pages()) begin
                  if (held_valid) batch.push_back(held_desc(UNLINKED, 1'b1));
                  held_valid   = 1'b0;
                  chain_halted = 1'b1;
               end else begin
                  slot_cursor   = cfg_page_base[next_page_idx % 4];
                  slots_left    = DESCS_PER_PAGE;
                  next_page_idx = next_page_idx + 1;
               end
            end
            if (!chain_halted) begin
               if (held_valid) batch.push_back(held_desc(slot_cursor | LINK_FLAG, 1'b0));
               held_valid  = 1'b1;
               held_slot   = slot_cursor;
               held_page   = page_ptr;
               slot_cursor = slot_cursor + ADDR_W'(DESC_BYTES);
               slots_left  = slots_left - 1;
               page_ptr    = page_ptr + ADDR_W'(PAGE_BYTES);
            end
            j++;
         end
      end
      if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) expected_descs.push_back(batch[k]);
   endtask

   // ------------------------------------------------------------ drivers

   function automatic logic [ADDR_W-1:0] rand_addr();
      return {$urandom, $urandom};
   endfunction

   // one request beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                            input logic [BYTES_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_block_addr  <= a;
      req_block_bytes <= b;
      do @(posedge clock); while (req_stall);
      chain_step(f, a, b);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PAGE_COUNT:  cfg_page_count   = data[PGIDX_W-1:0];
         CSR_PAGE_BASE_0: cfg_page_base[0] = data;
         CSR_PAGE_BASE_1: cfg_page_base[1] = data;
         CSR_PAGE_BASE_2: cfg_page_base[2] = data;
         CSR_PAGE_BASE_3: cfg_page_base[3] = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [PGIDX_W-1:0] count, input logic [ADDR_W-1:0] a0,
                            input logic [ADDR_W-1:0] a1, input logic [ADDR_W-1:0] a2,
                            input logic [ADDR_W-1:0] a3);
      logic [ADDR_W-1:0] count_word;
      // junk in the upper bits of the count write
      count_word = rand_addr();
      count_word[PGIDX_W-1:0] = count;
      write_csr(CSR_PAGE_COUNT, count_word);
      write_csr(CSR_PAGE_BASE_0, a0);
      write_csr(CSR_PAGE_BASE_1, a1);
      write_csr(CSR_PAGE_BASE_2, a2);
      write_csr(CSR_PAGE_BASE_3, a3);
   endtask

   task automatic set_idling(input int send_pct, input int hold_pct);
      send_idle_pct = send_pct;
      rsp_hold_pct  = hold_pct;
   endtask

   // drop valid, collect every pending result, then let silent work finish
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_descs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver back-pressure
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rsp_hold_pct);

   // ----------------------------------------------------------- checker

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_desc.slot_addr = rsp_slot_addr;
         seen_desc.page_word = rsp_page_word;
         seen_desc.size_word = rsp_size_word;
         seen_desc.next_word = rsp_next_word;
         seen_desc.last      = rsp_last;
         seen_desc.overflow  = rsp_overflow;
         if (expected_descs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t unexpected descriptor: slot %h page %h next %h",
                        $realtime, rsp_slot_addr, rsp_page_word, rsp_next_word);
         end else begin
            want_desc = expected_descs.pop_front();
            if (seen_desc !== want_desc) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t descriptor mismatch (expected / actual):", $realtime);
                  $display("  slot %h / %h  page %h / %h", want_desc.slot_addr,
                           seen_desc.slot_addr, want_desc.page_word, seen_desc.page_word);
                  $display("  size %h / %h  next %h / %h", want_desc.size_word,
                           seen_desc.size_word, want_desc.next_word, seen_desc.next_word);
                  $display("  last %b / %b  overflow %b / %b", want_desc.last,
                           seen_desc.last, want_desc.overflow, seen_desc.overflow);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------- tests

   // mapping straight out of reset, then closing that chain
   task automatic test_before_start();
      set_idling(0, 0);
      send_beat(FUNC_MAP, 64'h0000_1234_5678_9000, BYTES_W'(PAGE_BYTES * 3));
      send_beat(FUNC_FINISH, rand_addr(), BYTES_W'($urandom));
      wait_idle();
   endtask

   // size edges, page saturation, address wrap, unused code, halted beats
   task automatic test_block_sizes();
      set_idling(0, 0);
      send_beat(FUNC_START, ALL_ONES, 18'h3FFFF);
      send_beat(FUNC_MAP, ALL_ONES, 18'd0);
      send_beat(FUNC_UNUSED, ALL_ONES, 18'h3FFFF);
      send_beat(FUNC_MAP, 64'h0000_0000_0040_0000, BYTES_W'(PAGE_BYTES - 1));
      send_beat(FUNC_MAP, 64'h0000_0000_0080_0000, BYTES_W'(PAGE_BYTES));
      send_beat(FUNC_MAP, 64'hFFFF_FFFF_FFFF_F000,
                BYTES_W'(PAGE_BYTES * MAX_PAGES_PER_BLOCK));
      send_beat(FUNC_MAP, 64'd0, 18'h3FFFF);
      send_beat(FUNC_FINISH, 64'd0, 18'd0);
      send_beat(FUNC_MAP, rand_addr(), BYTES_W'(PAGE_BYTES * 2));
      wait_idle();
   endtask

   // address registers changed mid-chain: cursor holds, later pages and
   // the wrap target are picked up when needed
   task automatic test_live_reconfig();
      set_idling(0, 0);
      configure(3'd2, 64'hFFFF_FFFF_FFFF_FF00, 64'h0000_0000_8000_0000,
                64'h0000_0001_0000_0000, 64'h0000_0002_0000_0000);
      send_beat(FUNC_START, 64'd0, 18'd0);
      send_beat(FUNC_MAP, 64'hFFFF_FFFF_FFFF_8000, BYTES_W'(PAGE_BYTES * 20));
      wait_idle();
      write_csr(CSR_PAGE_BASE_0, 64'h0000_0000_0001_0000);
      write_csr(CSR_PAGE_BASE_1, 64'h0000_0000_C000_0000);
      repeat (4) send_beat(FUNC_MAP, rand_addr(), BYTES_W'(PAGE_BYTES * MAX_PAGES_PER_BLOCK));
      send_beat(FUNC_FINISH, 64'd0, 18'd0);
      wait_idle();
   endtask

   // page count of zero acts as one; run out of slots, then stay halted
   task automatic test_overflow();
      set_idling(0, 0);
      configure(3'd0, 64'h0000_00F0_0000_0000, rand_addr(), rand_addr(), rand_addr());
      send_beat(FUNC_START, 64'd0, 18'd0);
      repeat (5) send_beat(FUNC_MAP, rand_addr(), BYTES_W'(PAGE_BYTES * MAX_PAGES_PER_BLOCK));
      send_beat(FUNC_MAP, rand_addr(), BYTES_W'(PAGE_BYTES));
      wait_idle();
   endtask

   // random chains: start, maps with random content, usually a finish;
   // bulk chains push far enough to use every descriptor page
   task automatic test_random_chains(input int n_items, input int bulk_pct);
      int               sent;
      int               n_maps;
      bit               bulk;
      logic [BYTES_W-1:0] nbytes;
      sent = 0;
      while (sent < n_items) begin
         bulk   = ($urandom_range(99) < bulk_pct);
         n_maps = bulk ? $urandom_range(19, 22) : $urandom_range(1, 8);
         send_beat(FUNC_START, rand_addr(), BYTES_W'($urandom));
         sent++;
         repeat (n_maps) begin
            // stray beats that break or disturb the chain
            if ($urandom_range(99) < 8) begin
               case ($urandom_range(2))
                  0:       send_beat(FUNC_UNUSED, rand_addr(), BYTES_W'($urandom));
                  1:       send_beat(FUNC_FINISH, rand_addr(), BYTES_W'($urandom));
                  default: send_beat(FUNC_START, rand_addr(), BYTES_W'($urandom));
               endcase
            end
            if (bulk) begin
               nbytes = BYTES_W'($urandom_range(170000, 262143));
            end else begin
               case ($urandom_range(9))
                  0:       nbytes = BYTES_W'($urandom_range(0, PAGE_BYTES - 1));
                  1:       nbytes = BYTES_W'($urandom);
                  2, 3:    nbytes = BYTES_W'($urandom_range(PAGE_BYTES * 8,
                                                            PAGE_BYTES * 21 - 1));
                  default: nbytes = BYTES_W'($urandom_range(PAGE_BYTES, PAGE_BYTES * 5 - 1));
               endcase
            end
            send_beat(FUNC_MAP, rand_addr(), nbytes);
            sent++;
         end
         if ($urandom_range(99) < 85) begin
            send_beat(FUNC_FINISH, rand_addr(), BYTES_W'($urandom));
            sent++;
         end
         // a further map, which is dropped if the chain is closed
         if ($urandom_range(99) < 10) send_beat(FUNC_MAP, rand_addr(), BYTES_W'(PAGE_BYTES * 2));
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------- sequence

   initial begin
      cfg_page_count = PAGE_COUNT_RESET;
      foreach (cfg_page_base[i]) cfg_page_base[i] = '0;
      chain_restart();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_start();
      test_block_sizes();
      test_live_reconfig();
      test_overflow();

      set_idling(0, 0);
      configure(3'd1, 64'd0, ALL_ONES, ALL_ONES, ALL_ONES);
      test_random_chains(55, 25);

      set_idling(70, 0);
      configure(3'd2, rand_addr(), rand_addr(), rand_addr(), rand_addr());
      test_random_chains(55, 15);

      set_idling(0, 70);
      configure(3'd7, 64'hFFFF_FFFF_FFFF_FFEC, 64'd0, rand_addr(), ALL_ONES);
      test_random_chains(55, 30);

      set_idling(12, 12);
      configure(3'd4, rand_addr(), rand_addr(), rand_addr(), rand_addr());
      test_random_chains(55, 10);

      set_idling(0, 0);
      if (mismatch_count == 0 && expected_descs.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
src/dcb_pkg.sv
src/dcb_front.sv
src/dcb_queue.sv
src/dcb_back.sv
src/dma_descriptor_chain_builder.sv
tb/tb_dma_descriptor_chain_builder.sv
